### hdl/frustum_plane_extractor_assert.svh
// ----------------------------------------------------------------------------
// Frustum plane extractor assertion macros
// Concurrent assertion wrappers, left empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_EXTRACTOR_ASSERT_SVH
`define FRUSTUM_PLANE_EXTRACTOR_ASSERT_SVH

`ifndef SYNTHESIS

`define FPE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpe: same-cycle check failed");

`define FPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpe: next-cycle check failed");

`else

`define FPE_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define FPE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/fpe_pkg.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor package
// Shared codes, control types, microprogram table and saturation helpers.
// ----------------------------------------------------------------------------
package fpe_pkg;

   localparam int PLANE_COUNT = 5;
   localparam int STEP_W      = 7;

   localparam logic [1:0] KIND_VIEW    = 2'd0;
   localparam logic [1:0] KIND_PROJ    = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;

   localparam logic [1:0] OP_NOP  = 2'd0;
   localparam logic [1:0] OP_MAC  = 2'd1;
   localparam logic [1:0] OP_EMIT = 2'd2;
   localparam logic [1:0] OP_END  = 2'd3;

   localparam logic JC_NONE     = 1'b0;
   localparam logic JC_OUT_BUSY = 1'b1;

   localparam int MAC_STEPS  = 64;
   localparam int WAIT_STEPS = 4;
   localparam int EMIT_FIRST = MAC_STEPS + WAIT_STEPS;
   localparam int END_STEP   = EMIT_FIRST + PLANE_COUNT;

   typedef struct packed {
      logic [1:0]        op;
      logic [3:0]        va;
      logic [3:0]        pa;
      logic              first;
      logic              last;
      logic [3:0]        dest;
      logic [2:0]        plane;
      logic [1:0]        col;
      logic              neg;
      logic              jcond;
      logic [STEP_W-1:0] jtarget;
   } ctl_word_type;

   typedef struct packed {
      logic       mac_en;
      logic [3:0] va;
      logic [3:0] pa;
      logic       first;
      logic       last;
      logic [3:0] dest;
      logic       emit_en;
      logic [2:0] plane;
      logic [1:0] col;
      logic       neg;
   } dp_ctl_type;

   typedef struct packed {
      logic       en;
      logic       first;
      logic       last;
      logic [3:0] dest;
   } mac_tag_type;

   typedef struct packed {
      logic        en;
      logic [3:0]  dest;
      logic [31:0] value;
   } wb_type;

   // Plane order: right, left, top, bottom, far
   function automatic logic [1:0] plane_col(input logic [2:0] p);
      logic [1:0] c;
      case (p)
         3'd0, 3'd1: c = 2'd0;
         3'd2, 3'd3: c = 2'd1;
         default:    c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic plane_neg(input logic [2:0] p);
      return ~p[0];
   endfunction

   // Microprogram: 64 MACs (row, col, k with k innermost), pipeline drain,
   // one emit per plane (holding while the output is busy), then end.
   function automatic ctl_word_type prog_word(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      logic [2:0]   p;
      w         = '0;
      w.op      = OP_END;
      w.jcond   = JC_NONE;
      w.jtarget = step;
      p         = 3'(step - STEP_W'(EMIT_FIRST));
      if (step < STEP_W'(MAC_STEPS)) begin
         w.op    = OP_MAC;
         w.va    = {step[5:4], step[1:0]};
         w.pa    = {step[1:0], step[3:2]};
         w.dest  = {step[5:4], step[3:2]};
         w.first = (step[1:0] == 2'd0);
         w.last  = (step[1:0] == 2'd3);
      end else if (step < STEP_W'(EMIT_FIRST)) begin
         w.op = OP_NOP;
      end else if (step < STEP_W'(END_STEP)) begin
         w.op    = OP_EMIT;
         w.plane = p;
         w.col   = plane_col(p);
         w.neg   = plane_neg(p);
         w.jcond = JC_OUT_BUSY;
      end
      return w;
   endfunction

   function automatic logic [31:0] sat_acc(input logic [65:0] acc);
      logic [31:0] r;
      if ((&acc[65:47]) || !(|acc[65:47])) begin
         r = acc[47:16];
      end else if (acc[65]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

   function automatic logic [31:0] sat33(input logic [32:0] s);
      logic [31:0] r;
      if (s[32] == s[31]) begin
         r = s[31:0];
      end else if (s[32]) begin
         r = 32'h8000_0000;
      end else begin
         r = 32'h7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

### hdl/fpe_seq.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor sequencer
// Step counter over the microprogram table, with hold-while-busy jumps.
// ----------------------------------------------------------------------------
module fpe_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                out_free,
   output logic                busy,
   output fpe_pkg::dp_ctl_type ctl
);
   import fpe_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   ctl_word_type      word;
   logic              hold;

   assign word = prog_word(step_ff);
   assign hold = (word.jcond == JC_OUT_BUSY) && !out_free;

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = '0;
         end
      end else if (word.op == OP_END) begin
         busy_in = 1'b0;
         step_in = '0;
      end else if (hold) begin
         step_in = word.jtarget;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      ctl         = '0;
      ctl.mac_en  = busy_ff && (word.op == OP_MAC);
      ctl.va      = word.va;
      ctl.pa      = word.pa;
      ctl.first   = word.first;
      ctl.last    = word.last;
      ctl.dest    = word.dest;
      ctl.emit_en = busy_ff && (word.op == OP_EMIT) && out_free;
      ctl.plane   = word.plane;
      ctl.col     = word.col;
      ctl.neg     = word.neg;
   end

   assign busy = busy_ff;

endmodule

### hdl/fpe_mac.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor multiply-accumulate datapath
// Matrix stores, registered operand read, 32x32 multiplier, 66-bit accumulator.
// ----------------------------------------------------------------------------
module fpe_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                view_we,
   input  logic                proj_we,
   input  logic [3:0]          wr_index,
   input  logic [31:0]         wr_value,
   input  fpe_pkg::dp_ctl_type ctl,
   output fpe_pkg::wb_type     wb
);
   import fpe_pkg::*;

   logic [31:0]        view_mem_ff [16];
   logic [31:0]        proj_mem_ff [16];
   logic signed [31:0] op_a_ff, op_b_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic [65:0]        acc_ff, acc_in;
   mac_tag_type        s1_ff, s2_ff;
   logic               wb_ff;
   logic [3:0]         wb_dest_ff;

   always_ff @(posedge clock) begin
      if (view_we) begin
         view_mem_ff[wr_index] <= wr_value;
      end
      if (proj_we) begin
         proj_mem_ff[wr_index] <= wr_value;
      end
      op_a_ff <= view_mem_ff[ctl.va];
      op_b_ff <= proj_mem_ff[ctl.pa];
   end

   assign prod_in = op_a_ff * op_b_ff;

   always_comb begin
      if (s2_ff.first) begin
         acc_in = {{2{prod_ff[63]}}, prod_ff};
      end else begin
         acc_in = acc_ff + {{2{prod_ff[63]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.en) begin
         acc_ff <= acc_in;
      end
      wb_dest_ff <= s2_ff.dest;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         wb_ff <= 1'b0;
      end else begin
         s1_ff <= '{en: ctl.mac_en, first: ctl.first, last: ctl.last, dest: ctl.dest};
         s2_ff <= s1_ff;
         wb_ff <= s2_ff.en && s2_ff.last;
      end
   end

   assign wb.en    = wb_ff;
   assign wb.dest  = wb_dest_ff;
   assign wb.value = sat_acc(acc_ff);

endmodule

### hdl/fpe_plane.sv
// ----------------------------------------------------------------------------
// Frustum plane extractor plane stage
// Product row lanes, saturating add/subtract per component, result register.
// ----------------------------------------------------------------------------
module fpe_plane (
   input  logic                clock,
   input  logic                reset,
   input  fpe_pkg::wb_type     wb,
   input  fpe_pkg::dp_ctl_type ctl,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_plane_index,
   output logic signed [31:0]  rsp_normal_x,
   output logic signed [31:0]  rsp_normal_y,
   output logic signed [31:0]  rsp_normal_z,
   output logic signed [31:0]  rsp_plane_offset,
   output logic                rsp_last
);
   import fpe_pkg::*;

   logic [31:0] row_ff [4][4];
   logic [31:0] comp [4];
   logic        rsp_valid_ff;
   logic [2:0]  plane_ff;
   logic [31:0] comp_ff [4];
   logic        last_ff;

   // one lane per product row: col 3 against the selected column
   for (genvar r = 0; r < 4; r++) begin : g_lane
      logic signed [32:0] a, b, s;
      always_ff @(posedge clock) begin
         if (wb.en && (wb.dest[3:2] == 2'(r))) begin
            row_ff[r][wb.dest[1:0]] <= wb.value;
         end
      end
      assign a = {row_ff[r][3][31], row_ff[r][3]};
      assign b = {row_ff[r][ctl.col][31], row_ff[r][ctl.col]};
      assign s = ctl.neg ? (a - b) : (a + b);
      assign comp[r] = sat33(s);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit_en) begin
         plane_ff <= ctl.plane;
         comp_ff  <= comp;
         last_ff  <= (ctl.plane == 3'(PLANE_COUNT - 1));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_plane_index  = plane_ff;
   assign rsp_normal_x     = comp_ff[0];
   assign rsp_normal_y     = comp_ff[1];
   assign rsp_normal_z     = comp_ff[2];
   assign rsp_plane_offset = comp_ff[3];
   assign rsp_last         = last_ff;

endmodule

### hdl/frustum_plane_extractor.sv
// Load items do not make the block busy; the input stays ready for the next item.
// A compute item runs 64 multiply-accumulate steps through one 32x32
// multiplier, then a pipeline drain; the planes are shown after the drain,
// one plane per cycle while rsp_ready stays high.
// The input is held off until the compute ends, including any rsp stalls.
// Synchronous reset clears control only; matrix stores are not cleared.
// ----------------------------------------------------------------------------
// Frustum plane extractor
// Microcoded 4x4 matrix product and five clip planes in Q16.16.
// ----------------------------------------------------------------------------
`include "frustum_plane_extractor_assert.svh"

module frustum_plane_extractor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [3:0]         req_elem_index,
   input  logic signed [31:0] req_elem_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_plane_index,
   output logic signed [31:0] rsp_normal_x,
   output logic signed [31:0] rsp_normal_y,
   output logic signed [31:0] rsp_normal_z,
   output logic signed [31:0] rsp_plane_offset,
   output logic               rsp_last
);
   import fpe_pkg::*;

   localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

   logic       busy;
   logic       out_free;
   logic       xfer;
   dp_ctl_type ctl;
   wb_type     wb;

   assign req_ready = !busy;
   assign xfer      = req_valid && req_ready;

   fpe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (xfer && (req_kind == KIND_COMPUTE)),
      .out_free (out_free),
      .busy     (busy),
      .ctl      (ctl)
   );

   fpe_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .view_we  (xfer && (req_kind == KIND_VIEW)),
      .proj_we  (xfer && (req_kind == KIND_PROJ)),
      .wr_index (req_elem_index),
      .wr_value (req_elem_value),
      .ctl      (ctl),
      .wb       (wb)
   );

   fpe_plane u_plane (
      .clock            (clock),
      .reset            (reset),
      .wb               (wb),
      .ctl              (ctl),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_plane_index  (rsp_plane_index),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_plane_offset (rsp_plane_offset),
      .rsp_last         (rsp_last)
   );

   `FPE_ASSERT_IMPLY(a_emit_room, clock, reset, ctl.emit_en, out_free)
   `FPE_ASSERT_IMPLY(a_wb_not_emit, clock, reset, wb.en, !ctl.emit_en)
   `FPE_ASSERT_NEXT(a_compute_busy, clock, reset, xfer && (req_kind == KIND_COMPUTE), busy)
   `FPE_ASSERT_IMPLY(a_last_plane, clock, reset, rsp_valid && rsp_last, rsp_plane_index == LAST_PLANE)

endmodule
